// ===== rtl/ckt_pkg.sv =====
// ckt_pkg: shared sizes, codes and record types of the compacting key table
// used by the interfaces, the entry store, the sequencer and the checker
package ckt_pkg;

  // table depth and the widths that follow from it
  localparam int MAX_ENTRIES = 8;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // fixed field widths of the command and result records
  localparam int KIND_W   = 3;
  localparam int KEY_W    = 64;
  localparam int LANG_W   = 8;
  localparam int MAXC_W   = 7;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;

  // command codes
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD,
    KIND_REMOVE,
    KIND_SET_LANG,
    KIND_SET_ALERT,
    KIND_LOOKUP,
    KIND_FIRST,
    KIND_LIST_ALERT,
    KIND_LIST_ALL
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK,
    STATUS_NOT_FOUND,
    STATUS_FULL
  } status_t;

  // one table entry
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [LANG_W-1:0]       language;
    logic                    alerts;
  } entry_t;

  // write port of the entry store
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } store_wr_t;

  // one result record
  typedef struct packed {
    status_t                 status;
    logic                    entry_valid;
    logic signed [KEY_W-1:0] key_out;
    logic [LANG_W-1:0]       language_out;
    logic                    alerts_out;
    logic [SLOT_W-1:0]       slot_out;
    logic [COUNT_W-1:0]      count_out;
    logic                    last;
  } rsp_t;

endpackage

// ===== rtl/ckt_if.sv =====
// ckt_if: valid/ready channels of the compacting key table
// command, result and configuration channels; depends on ckt_pkg
interface ckt_cmd_if;
  import ckt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic signed [KEY_W-1:0] key;
  logic [LANG_W-1:0]       language_in;
  logic                    alerts_in;
  logic [MAXC_W-1:0]       max_count;

  modport source (output valid, kind, key, language_in, alerts_in, max_count, input ready);
  modport sink (input valid, kind, key, language_in, alerts_in, max_count, output ready);
endinterface

interface ckt_rsp_if;
  import ckt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic                    entry_valid;
  logic signed [KEY_W-1:0] key_out;
  logic [LANG_W-1:0]       language_out;
  logic                    alerts_out;
  logic [SLOT_W-1:0]       slot_out;
  logic [COUNT_W-1:0]      count_out;
  logic                    last;

  modport source (output valid, status, entry_valid, key_out, language_out, alerts_out,
                  slot_out, count_out, last, input ready);
  modport sink (input valid, status, entry_valid, key_out, language_out, alerts_out,
                slot_out, count_out, last, output ready);
endinterface

interface ckt_cfg_if;
  import ckt_pkg::*;
  logic              valid;
  logic              ready;
  logic [LANG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/ckt_store.sv =====
// ckt_store: flop-based entry store, one write and one read port
// read is combinational on the sequencer's index; depends on ckt_pkg
module ckt_store (
  input  logic                     clk,
  input  ckt_pkg::store_wr_t       wr,
  input  logic [ckt_pkg::IDX_W-1:0] rd_addr,
  output ckt_pkg::entry_t          rd_data
);
  import ckt_pkg::*;

  entry_t entries [MAX_ENTRIES];

  // single write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      entries[wr.addr] <= wr.data;
    end
  end

  // single read port
  assign rd_data = entries[rd_addr];

endmodule

// ===== rtl/ckt_seq.sv =====
// ckt_seq: command sequencer with the shared key comparator and result register
// walks the entry store one slot a cycle while no list result is stalled; depends on ckt_pkg, ckt_if, ckt_store
module ckt_seq (
  input  logic                      clk,
  input  logic                      rst,
  ckt_cmd_if.sink                   cmd,
  ckt_rsp_if.source                 rsp,
  input  logic [ckt_pkg::LANG_W-1:0] default_language,
  output logic [ckt_pkg::IDX_W-1:0]  rd_addr,
  input  ckt_pkg::entry_t           rd_data,
  output ckt_pkg::store_wr_t        wr
);
  import ckt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_ACT,
    S_SHIFT,
    S_EMIT,
    S_LIST,
    S_LIST_END
  } state_t;

  state_t                  state;
  kind_t                   kind_r;
  logic signed [KEY_W-1:0] key_r;
  logic [LANG_W-1:0]       lang_r;
  logic                    alert_r;
  logic [MAXC_W-1:0]       maxc_r;
  logic [CNT_W-1:0]        idx;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        emitted;
  logic [IDX_W-1:0]        slot_r;
  logic                    found_r;
  status_t                 status_r;
  logic                    ev_r;
  logic                    pend_valid;
  entry_t                  pend_entry;
  logic [IDX_W-1:0]        pend_slot;
  logic                    rsp_valid_r;
  rsp_t                    rsp_r;

  logic in_range;
  logic key_hit;
  logic full;
  logic out_free;
  logic list_more;
  logic list_qual;
  logic rsp_load;

  // builds one result record; fields of an absent entry read as zero
  function automatic rsp_t make_rsp(status_t st, logic ev, entry_t e,
                                    logic [IDX_W-1:0] sl, logic [CNT_W-1:0] cnt,
                                    logic lst);
    rsp_t r;
    r             = '0;
    r.status      = st;
    r.entry_valid = ev;
    if (ev) begin
      r.key_out      = e.key;
      r.language_out = e.language;
      r.alerts_out   = e.alerts;
      r.slot_out     = SLOT_W'(sl);
    end
    r.count_out = COUNT_W'(cnt);
    r.last      = lst;
    return r;
  endfunction

  // shared comparator and scan conditions
  assign in_range  = (idx < count);
  assign key_hit   = in_range && (rd_data.key == key_r);
  assign full      = (count == CNT_W'(MAX_ENTRIES));
  assign out_free  = !rsp_valid_r || rsp.ready;
  assign list_more = in_range && (MAXC_W'(emitted) < maxc_r);
  assign list_qual = (kind_r == KIND_LIST_ALL) || rd_data.alerts;

  // result register loads this cycle
  assign rsp_load = out_free && ((state == S_EMIT) || (state == S_LIST_END) ||
                                 ((state == S_LIST) && list_more && list_qual && pend_valid));

  // read address of the store
  always_comb begin
    case (state)
      S_SHIFT: rd_addr = IDX_W'(idx + CNT_W'(1));
      S_EMIT:  rd_addr = slot_r;
      default: rd_addr = idx[IDX_W-1:0];
    endcase
  end

  // write port of the store
  always_comb begin
    wr = '0;
    case (state)
      S_ACT: begin
        case (kind_r)
          KIND_ADD: begin
            if (!found_r && !full) begin
              wr.en            = 1'b1;
              wr.addr          = count[IDX_W-1:0];
              wr.data.key      = key_r;
              wr.data.language = default_language;
              wr.data.alerts   = 1'b1;
            end
          end
          KIND_SET_LANG: begin
            if (found_r) begin
              wr.en            = 1'b1;
              wr.addr          = slot_r;
              wr.data          = rd_data;
              wr.data.language = lang_r;
            end
          end
          KIND_SET_ALERT: begin
            if (found_r) begin
              wr.en          = 1'b1;
              wr.addr        = slot_r;
              wr.data        = rd_data;
              wr.data.alerts = alert_r;
            end
          end
          default: wr.en = 1'b0;
        endcase
      end
      // move the next entry up, then clear the freed last slot
      S_SHIFT: begin
        wr.en   = 1'b1;
        wr.addr = idx[IDX_W-1:0];
        wr.data = in_range ? rd_data : '0;
      end
      default: wr.en = 1'b0;
    endcase
  end

  // handshakes and result payload
  assign cmd.ready        = (state == S_IDLE);
  assign rsp.valid        = rsp_valid_r;
  assign rsp.status       = rsp_r.status;
  assign rsp.entry_valid  = rsp_r.entry_valid;
  assign rsp.key_out      = rsp_r.key_out;
  assign rsp.language_out = rsp_r.language_out;
  assign rsp.alerts_out   = rsp_r.alerts_out;
  assign rsp.slot_out     = rsp_r.slot_out;
  assign rsp.count_out    = rsp_r.count_out;
  assign rsp.last         = rsp_r.last;

  // sequencer, entry count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      pend_valid  <= 1'b0;
      rsp_valid_r <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid_r <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_r <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            kind_r     <= kind_t'(cmd.kind);
            key_r      <= cmd.key;
            lang_r     <= cmd.language_in;
            alert_r    <= cmd.alerts_in;
            maxc_r     <= cmd.max_count;
            idx        <= '0;
            emitted    <= '0;
            found_r    <= 1'b0;
            pend_valid <= 1'b0;
            case (kind_t'(cmd.kind))
              KIND_FIRST: begin
                slot_r   <= '0;
                ev_r     <= (count != '0);
                status_r <= (count != '0) ? STATUS_OK : STATUS_NOT_FOUND;
                state    <= S_EMIT;
              end
              KIND_LIST_ALERT, KIND_LIST_ALL: state <= S_LIST;
              default: state <= S_SEARCH;
            endcase
          end
        end
        // one slot compared per cycle
        S_SEARCH: begin
          if (!in_range) begin
            state <= S_ACT;
          end else if (key_hit) begin
            found_r <= 1'b1;
            slot_r  <= idx[IDX_W-1:0];
            state   <= S_ACT;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end
        S_ACT: begin
          case (kind_r)
            KIND_ADD: begin
              state <= S_EMIT;
              if (found_r) begin
                status_r <= STATUS_OK;
                ev_r     <= 1'b1;
              end else if (full) begin
                status_r <= STATUS_FULL;
                ev_r     <= 1'b0;
              end else begin
                status_r <= STATUS_OK;
                slot_r   <= count[IDX_W-1:0];
                count    <= count + CNT_W'(1);
                ev_r     <= 1'b1;
              end
            end
            KIND_REMOVE: begin
              ev_r <= 1'b0;
              if (found_r) begin
                status_r <= STATUS_OK;
                count    <= count - CNT_W'(1);
                state    <= S_SHIFT;
              end else begin
                status_r <= STATUS_NOT_FOUND;
                state    <= S_EMIT;
              end
            end
            default: begin
              state    <= S_EMIT;
              ev_r     <= found_r;
              status_r <= found_r ? STATUS_OK : STATUS_NOT_FOUND;
            end
          endcase
        end
        S_SHIFT: begin
          if (in_range) begin
            idx <= idx + CNT_W'(1);
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            rsp_r <= make_rsp(status_r, ev_r, rd_data, slot_r, count, 1'b1);
            state <= S_IDLE;
          end
        end
        // a found key is held back until the next one shows it is not the last
        S_LIST: begin
          if (!list_more) begin
            state <= S_LIST_END;
          end else if (!list_qual) begin
            idx <= idx + CNT_W'(1);
          end else if (!pend_valid || out_free) begin
            if (pend_valid) begin
              rsp_r <= make_rsp(STATUS_OK, 1'b1, pend_entry, pend_slot, count, 1'b0);
            end
            pend_valid <= 1'b1;
            pend_entry <= rd_data;
            pend_slot  <= idx[IDX_W-1:0];
            emitted    <= emitted + CNT_W'(1);
            idx        <= idx + CNT_W'(1);
          end
        end
        S_LIST_END: begin
          if (out_free) begin
            rsp_r      <= make_rsp(STATUS_OK, pend_valid, pend_entry, pend_slot, count,
                                   1'b1);
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/compacting_key_table.sv =====
// compacting_key_table: packed table of keys with language code and alert flag
// holds the default language register; depends on ckt_pkg, ckt_if, ckt_store, ckt_seq
//
// Usage
//   cmd : one command per transfer (kind, key, language_in, alerts_in, max_count).
//   rsp : results; every command gives one result, a list gives one per key
//         emitted or one with no entry, and last marks the final result of the command.
//   cfg : writes default_language, taken in any cycle (ready is always high);
//         write it only while no command is in progress.
// Sequencing
//   The sequencer visits one slot per cycle through the single read port of
//   the entry store, unless a list result waits on rsp. Add, remove, set and
//   lookup search the occupied slots until a hit or the end, then act (S_ACT)
//   and load the result register (S_EMIT). Remove first moves later entries
//   up (S_SHIFT). First entry goes straight to S_EMIT. A list walks the
//   slots in S_LIST and ends in S_LIST_END, holding on any stall on rsp.
//   cmd is ready only when the sequencer is idle: one command at a time.
// Reset
//   rst (synchronous) empties the table, clears default_language and drops rsp.
// Stalls
//   A result waits in the output register while rsp.ready is low; the
//   sequencer holds its place and resumes as the register frees.
module compacting_key_table (
  input  logic       clk,
  input  logic       rst,
  ckt_cfg_if.sink    cfg,
  ckt_cmd_if.sink    cmd,
  ckt_rsp_if.source  rsp
);
  import ckt_pkg::*;

  logic [LANG_W-1:0] default_language;
  logic [IDX_W-1:0]  rd_addr;
  entry_t            rd_data;
  store_wr_t         wr;

  // configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_language <= '0;
    end else if (cfg.valid) begin
      default_language <= cfg.data;
    end
  end

  // entry store
  ckt_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // command sequencer
  ckt_seq u_seq (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .rsp              (rsp),
    .default_language (default_language),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .wr               (wr)
  );

endmodule

// ===== rtl/ckt_check.sv =====
// ckt_check: port-level assertions for the compacting key table
// attached to the top level by bind; depends on ckt_pkg
module ckt_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        cmd_valid,
  input logic                        cmd_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [ckt_pkg::STATUS_W-1:0] rsp_status,
  input logic                        rsp_entry_valid,
  input logic [ckt_pkg::KEY_W-1:0]    rsp_key_out,
  input logic [ckt_pkg::LANG_W-1:0]   rsp_language_out,
  input logic                        rsp_alerts_out,
  input logic [ckt_pkg::SLOT_W-1:0]   rsp_slot_out,
  input logic [ckt_pkg::COUNT_W-1:0]  rsp_count_out,
  input logic                        rsp_last
);
  import ckt_pkg::*;

  // a stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its key, slot, status and last flag
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_key_out) && $stable(rsp_last) &&
                                $stable(rsp_slot_out) && $stable(rsp_status))
    else $error("result payload changed while stalled");

  // one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while another is in progress");

  // a result without an entry carries zero entry fields
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_entry_valid |-> rsp_key_out == '0 && rsp_language_out == '0 &&
                                      !rsp_alerts_out && rsp_slot_out == '0)
    else $error("entry fields set on a result without an entry");

  // a reported entry lies inside the occupied slots and never comes with STATUS_FULL
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_entry_valid |-> rsp_slot_out < rsp_count_out &&
                                     rsp_count_out <= COUNT_W'(MAX_ENTRIES) &&
                                     rsp_status != STATUS_FULL)
    else $error("reported slot outside the table");

endmodule

bind compacting_key_table ckt_check u_ckt_check (
  .clk              (clk),
  .rst              (rst),
  .cmd_valid        (cmd.valid),
  .cmd_ready        (cmd.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_entry_valid  (rsp.entry_valid),
  .rsp_key_out      (rsp.key_out),
  .rsp_language_out (rsp.language_out),
  .rsp_alerts_out   (rsp.alerts_out),
  .rsp_slot_out     (rsp.slot_out),
  .rsp_count_out    (rsp.count_out),
  .rsp_last         (rsp.last)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking testbench of the compacting key table, with a scoreboard class
// that predicts every result. Depends on ckt_pkg, the ckt_*_if interfaces and the rtl.
module tb;
  import ckt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 24;
  localparam int HOLD_CYCLES = 300;

  // one command as offered on the command channel
  typedef struct {
    kind_t                   kind;
    logic signed [KEY_W-1:0] key;
    logic [LANG_W-1:0]       language;
    logic                    alerts;
    logic [MAXC_W-1:0]       max_count;
  } command_t;

  // shadow table and the results still owed by the block
  class key_table_scoreboard;
    logic signed [KEY_W-1:0] slot_keys [MAX_ENTRIES];
    logic [LANG_W-1:0]       slot_langs [MAX_ENTRIES];
    logic                    slot_alerts [MAX_ENTRIES];
    int                      used_slots;
    logic [LANG_W-1:0]       new_entry_lang;
    rsp_t                    pending_results [$];
    int                      mismatches;

    function new();
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        slot_keys[i]   = '0;
        slot_langs[i]  = '0;
        slot_alerts[i] = 1'b0;
      end
      used_slots     = 0;
      new_entry_lang = '0;
      mismatches     = 0;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 40) $display("tb: mismatch at %0t: %s", $realtime, what);
    endtask

    function int find_slot(logic signed [KEY_W-1:0] k);
      for (int i = 0; i < used_slots; i++)
        if (slot_keys[i] === k) return i;
      return -1;
    endfunction

    // result record; a negative slot means no entry is carried
    function rsp_t make_result(status_t st, int slot, bit fin);
      rsp_t r;
      r = '0;
      r.status = st;
      if (slot >= 0) begin
        r.entry_valid  = 1'b1;
        r.key_out      = slot_keys[slot];
        r.language_out = slot_langs[slot];
        r.alerts_out   = slot_alerts[slot];
        r.slot_out     = slot[SLOT_W-1:0];
      end
      r.count_out = used_slots[COUNT_W-1:0];
      r.last      = fin;
      return r;
    endfunction

    function void note_default_language(logic [LANG_W-1:0] v);
      new_entry_lang = v;
    endfunction

    // update the shadow table for an accepted command and queue its results
    function void note_command(command_t c);
      int slot;
      int emitted;
      slot = find_slot(c.key);
      case (c.kind)
        KIND_ADD: begin
          if (slot >= 0) begin
            pending_results.push_back(make_result(STATUS_OK, slot, 1'b1));
          end else if (used_slots >= MAX_ENTRIES) begin
            pending_results.push_back(make_result(STATUS_FULL, -1, 1'b1));
          end else begin
            slot_keys[used_slots]   = c.key;
            slot_langs[used_slots]  = new_entry_lang;
            slot_alerts[used_slots] = 1'b1;
            used_slots++;
            pending_results.push_back(make_result(STATUS_OK, used_slots - 1, 1'b1));
          end
        end
        KIND_REMOVE: begin
          if (slot < 0) begin
            pending_results.push_back(make_result(STATUS_NOT_FOUND, -1, 1'b1));
          end else begin
            used_slots--;
            for (int i = slot; i < used_slots; i++) begin
              slot_keys[i]   = slot_keys[i+1];
              slot_langs[i]  = slot_langs[i+1];
              slot_alerts[i] = slot_alerts[i+1];
            end
            slot_keys[used_slots]   = '0;
            slot_langs[used_slots]  = '0;
            slot_alerts[used_slots] = 1'b0;
            pending_results.push_back(make_result(STATUS_OK, -1, 1'b1));
          end
        end
        KIND_SET_LANG, KIND_SET_ALERT: begin
          if (slot < 0) begin
            pending_results.push_back(make_result(STATUS_NOT_FOUND, -1, 1'b1));
          end else begin
            if (c.kind == KIND_SET_LANG) slot_langs[slot] = c.language;
            else slot_alerts[slot] = c.alerts;
            pending_results.push_back(make_result(STATUS_OK, slot, 1'b1));
          end
        end
        KIND_LOOKUP: begin
          pending_results.push_back(
            make_result(slot < 0 ? STATUS_NOT_FOUND : STATUS_OK, slot, 1'b1));
        end
        KIND_FIRST: begin
          if (used_slots == 0)
            pending_results.push_back(make_result(STATUS_NOT_FOUND, -1, 1'b1));
          else
            pending_results.push_back(make_result(STATUS_OK, 0, 1'b1));
        end
        default: begin
          // both list commands: slot order, capped by max_count
          emitted = 0;
          for (int i = 0; i < used_slots && emitted < int'(c.max_count); i++) begin
            if (c.kind == KIND_LIST_ALL || slot_alerts[i]) begin
              pending_results.push_back(make_result(STATUS_OK, i, 1'b0));
              emitted++;
            end
          end
          if (emitted == 0) pending_results.push_back(make_result(STATUS_OK, -1, 1'b1));
          else pending_results[$].last = 1'b1;
        end
      endcase
    endfunction

    // compare one result transfer with the oldest expectation
    task check_result(rsp_t got);
      rsp_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.entry_valid !== want.entry_valid)
          report_mismatch($sformatf("entry_valid %0b, expected %0b",
                                    got.entry_valid, want.entry_valid));
        if (got.key_out !== want.key_out)
          report_mismatch($sformatf("key_out %h, expected %h", got.key_out, want.key_out));
        if (got.language_out !== want.language_out)
          report_mismatch($sformatf("language_out %h, expected %h",
                                    got.language_out, want.language_out));
        if (got.alerts_out !== want.alerts_out)
          report_mismatch($sformatf("alerts_out %0b, expected %0b",
                                    got.alerts_out, want.alerts_out));
        if (got.slot_out !== want.slot_out)
          report_mismatch($sformatf("slot_out %0d, expected %0d", got.slot_out, want.slot_out));
        if (got.count_out !== want.count_out)
          report_mismatch($sformatf("count_out %0d, expected %0d",
                                    got.count_out, want.count_out));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  bit   no_idle;
  bit   hold_request;
  bit   hold_off;
  int   sink_stall;
  int   cycles;
  logic signed [KEY_W-1:0] key_pool [12];

  key_table_scoreboard board = new();

  ckt_cfg_if cfg_ch ();
  ckt_cmd_if cmd_ch ();
  ckt_rsp_if rsp_ch ();

  compacting_key_table dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // clock and known input levels from time zero
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst                = 1'b1;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = '0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.kind        = '0;
    cmd_ch.key         = '0;
    cmd_ch.language_in = '0;
    cmd_ch.alerts_in   = 1'b0;
    cmd_ch.max_count   = '0;
    rsp_ch.ready       = 1'b0;
  end

  // gap length: mostly none or short, now and then long
  function automatic int idle_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side: check each transfer, then choose the next ready level
  always @(posedge clk) begin
    rsp_t got;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      sink_stall   = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status       = status_t'(rsp_ch.status);
        got.entry_valid  = rsp_ch.entry_valid;
        got.key_out      = rsp_ch.key_out;
        got.language_out = rsp_ch.language_out;
        got.alerts_out   = rsp_ch.alerts_out;
        got.slot_out     = rsp_ch.slot_out;
        got.count_out    = rsp_ch.count_out;
        got.last         = rsp_ch.last;
        board.check_result(got);
      end
      if (hold_off) begin
        rsp_ch.ready <= 1'b0;
      end else if (sink_stall > 0) begin
        rsp_ch.ready <= 1'b0;
        sink_stall--;
      end else begin
        sink_stall = idle_gap();
        if (sink_stall > 0) begin
          rsp_ch.ready <= 1'b0;
          sink_stall--;
        end else begin
          rsp_ch.ready <= 1'b1;
        end
      end
    end
  end

  // long receiver hold-off so that the block backs up into the command channel
  initial begin
    hold_off = 1'b0;
    wait (hold_request);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // offer one command and wait for its transfer
  task automatic issue_command(command_t c);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.kind        <= c.kind;
    cmd_ch.key         <= c.key;
    cmd_ch.language_in <= c.language;
    cmd_ch.alerts_in   <= c.alerts;
    cmd_ch.max_count   <= c.max_count;
    do @(posedge clk); while (!cmd_ch.ready);
    board.note_command(c);
  endtask

  // register write, only while the block is idle
  task automatic write_default_language(logic [LANG_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    board.note_default_language(v);
    cfg_ch.valid <= 1'b0;
  endtask

  // let the block drain before touching the register
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic command_t mk(kind_t k, logic signed [KEY_W-1:0] key,
                                  logic [LANG_W-1:0] lang = '0, logic al = 1'b0,
                                  int maxc = 0);
    command_t c;
    c.kind      = k;
    c.key       = key;
    c.language  = lang;
    c.alerts    = al;
    c.max_count = maxc[MAXC_W-1:0];
    return c;
  endfunction

  // random command: mostly keys from a small pool so that hits, full and
  // removal shifts happen often, with some strangers that miss
  function automatic command_t random_command();
    command_t c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 30)      c.kind = KIND_ADD;
    else if (r < 45) c.kind = KIND_REMOVE;
    else if (r < 55) c.kind = KIND_SET_LANG;
    else if (r < 65) c.kind = KIND_SET_ALERT;
    else if (r < 75) c.kind = KIND_LOOKUP;
    else if (r < 80) c.kind = KIND_FIRST;
    else if (r < 90) c.kind = KIND_LIST_ALERT;
    else             c.kind = KIND_LIST_ALL;
    if ($urandom_range(0, 99) < 85) c.key = key_pool[$urandom_range(0, 11)];
    else c.key = {$urandom, $urandom};
    c.language = LANG_W'($urandom_range(0, 255));
    c.alerts   = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) c.max_count = MAXC_W'($urandom_range(0, 64));
    else c.max_count = MAXC_W'($urandom_range(0, MAX_ENTRIES + 1));
    return c;
  endfunction

  // stimulus
  initial begin
    logic [LANG_W-1:0] phase_lang [4];
    no_idle      = 1'b0;
    hold_request = 1'b0;
    cycles       = 0;
    key_pool[0] = '0;
    key_pool[1] = {1'b1, {(KEY_W-1){1'b0}}};
    key_pool[2] = {1'b0, {(KEY_W-1){1'b1}}};
    key_pool[3] = '1;
    for (int i = 4; i < 12; i++) key_pool[i] = {$urandom, $urandom};
    phase_lang[0] = 8'h00;
    phase_lang[1] = LANG_W'($urandom_range(1, 254));
    phase_lang[2] = 8'ha5;
    phase_lang[3] = 8'hff;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, fill to full, duplicates, edits, lists, removals
    write_default_language(8'hff);
    issue_command(mk(KIND_FIRST, '0));
    issue_command(mk(KIND_LIST_ALL, '0, 8'h00, 1'b0, 64));
    issue_command(mk(KIND_LOOKUP, '0));
    issue_command(mk(KIND_REMOVE, key_pool[2]));
    issue_command(mk(KIND_SET_LANG, '0, 8'h3c));
    issue_command(mk(KIND_SET_ALERT, '0, 8'h00, 1'b1));
    issue_command(mk(KIND_ADD, key_pool[0]));
    issue_command(mk(KIND_ADD, key_pool[1]));
    issue_command(mk(KIND_ADD, key_pool[2]));
    issue_command(mk(KIND_ADD, key_pool[3]));
    issue_command(mk(KIND_ADD, 64'h5555_5555_5555_5555));
    issue_command(mk(KIND_ADD, 64'haaaa_aaaa_aaaa_aaaa));
    issue_command(mk(KIND_ADD, 64'sd1));
    issue_command(mk(KIND_ADD, 64'h0123_4567_89ab_cdef));
    issue_command(mk(KIND_ADD, 64'sd42));
    issue_command(mk(KIND_ADD, key_pool[2]));
    issue_command(mk(KIND_SET_LANG, key_pool[3], 8'h00));
    issue_command(mk(KIND_SET_ALERT, key_pool[1], 8'hff, 1'b0));
    issue_command(mk(KIND_LIST_ALERT, '0, 8'h00, 1'b0, 64));
    issue_command(mk(KIND_LIST_ALL, '0, 8'h00, 1'b0, 3));
    issue_command(mk(KIND_LIST_ALL, '0, 8'hff, 1'b1, 0));
    issue_command(mk(KIND_LOOKUP, key_pool[1]));
    issue_command(mk(KIND_REMOVE, key_pool[0]));
    issue_command(mk(KIND_REMOVE, 64'sd1));
    issue_command(mk(KIND_REMOVE, 64'h0123_4567_89ab_cdef));
    issue_command(mk(KIND_FIRST, '0));

    // random phases, each with its own default language
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      write_default_language(phase_lang[p]);
      no_idle = (p == 3);
      for (int n = 0; n < 26; n++) begin
        if (p == 1 && n == 8) hold_request = 1'b1;
        issue_command(random_command());
      end
    end

    // drain and finish
    cmd_ch.valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (board.pending_results.size() != 0) board.report_mismatch("expected results left over");
    if (board.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ckt_pkg.sv
rtl/ckt_if.sv
rtl/ckt_store.sv
rtl/ckt_seq.sv
rtl/compacting_key_table.sv
rtl/ckt_check.sv
tb/tb.sv
